// ----- src/lbz_pkg.sv -----
`timescale 1ns / 1ps
package lbz_pkg;

	localparam int BetaFracBits  = 30;
	localparam int GammaFracBits = 18;
	localparam int MaxNormPairs  = 15;

	// sideband that travels with each item through the long stages
	typedef struct packed {
		logic signed [31:0] energy;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic               bneg;
		logic        [29:0] bm;
		logic        [3:0]  m;
	} lbz_side_t;

endpackage

// ----- src/lbz_isqrt.sv -----
`timescale 1ns / 1ps
module lbz_isqrt import lbz_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [61:0] in_rad,
	input  lbz_side_t   in_side,
	output logic        out_valid,
	output logic [30:0] out_root,
	output lbz_side_t   out_side
);

	localparam int Steps = 31;

	logic        v_s    [0:Steps];
	logic [32:0] rem_s  [0:Steps];
	logic [30:0] root_s [0:Steps];
	logic [61:0] rad_s  [0:Steps];
	lbz_side_t   side_s [0:Steps];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = in_rad;
	assign side_s[0] = in_side;

	for (genvar j = 1; j <= Steps; j++) begin : g_step
		localparam int P = Steps - j;
		logic [32:0] r2;
		logic [32:0] trial;

		// bring down the next pair of radicand bits
		assign r2    = {rem_s[j-1][30:0], rad_s[j-1][2*P+1 -: 2]};
		assign trial = {root_s[j-1], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[j]  <= rad_s[j-1];
			side_s[j] <= side_s[j-1];
			if (r2 >= trial) begin
				rem_s[j]  <= r2 - trial;
				root_s[j] <= {root_s[j-1][29:0], 1'b1};
			end else begin
				rem_s[j]  <= r2;
				root_s[j] <= {root_s[j-1][29:0], 1'b0};
			end
		end
	end

	assign out_valid = v_s[Steps];
	assign out_root  = root_s[Steps];
	assign out_side  = side_s[Steps];

endmodule

// ----- src/lbz_recip.sv -----
`timescale 1ns / 1ps
module lbz_recip import lbz_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [30:0] in_root,
	input  lbz_side_t   in_side,
	output logic        out_valid,
	output logic [33:0] out_quo,
	output lbz_side_t   out_side
);

	// floor(2^63 / root), one quotient bit per stage
	localparam int Steps = 34;

	logic        v_s    [0:Steps];
	logic [31:0] rem_s  [0:Steps];
	logic [33:0] quo_s  [0:Steps];
	logic [30:0] den_s  [0:Steps];
	lbz_side_t   side_s [0:Steps];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = 32'd1 << 29;
	assign quo_s[0]  = '0;
	assign den_s[0]  = in_root;
	assign side_s[0] = in_side;

	for (genvar j = 1; j <= Steps; j++) begin : g_step
		logic [31:0] r2;

		assign r2 = {rem_s[j-1][30:0], 1'b0};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			den_s[j]  <= den_s[j-1];
			side_s[j] <= side_s[j-1];
			if (r2 >= {1'b0, den_s[j-1]}) begin
				rem_s[j] <= r2 - {1'b0, den_s[j-1]};
				quo_s[j] <= {quo_s[j-1][32:0], 1'b1};
			end else begin
				rem_s[j] <= r2;
				quo_s[j] <= {quo_s[j-1][32:0], 1'b0};
			end
		end
	end

	assign out_valid = v_s[Steps];
	assign out_quo   = quo_s[Steps];
	assign out_side  = side_s[Steps];

endmodule

// ----- src/lbz_boost.sv -----
`timescale 1ns / 1ps
module lbz_boost import lbz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic        [33:0] in_quo,
	input  lbz_side_t          in_side,
	output logic               out_valid,
	output logic signed [31:0] out_energy,
	output logic signed [31:0] out_px,
	output logic signed [31:0] out_py,
	output logic signed [31:0] out_pz,
	output logic               out_ovf
);

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	lbz_side_t   side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [33:0] gq_s1, gq_s2, gq_s3, gq_s4;
	logic [46:0] gbl_s3, gbh_s3;
	logic [33:0] gb_s4;
	logic signed [49:0] gel_s5, geh_s5, gzl_s5, gzh_s5;
	logic signed [49:0] bzl_s5, bzh_s5, bel_s5, beh_s5;
	logic signed [66:0] ge_s6, gz_s6, bz_s6, be_s6;
	logic signed [66:0] eo_s7, zo_s7;
	logic [63:0]        gb_full;
	logic signed [48:0] et, zt;
	logic               e_ovf, z_ovf;
	logic [3:0]         rsh;

	assign rsh     = 4'(MaxNormPairs) - side_s1.m;
	assign gb_full = ({17'd0, gbh_s3} << 17) + {17'd0, gbl_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			out_valid <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		// hold the raw quotient; scale it once m is at hand
		gq_s1   <= in_quo;
		side_s1 <= in_side;
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		gq_s2   <= gq_s1 >> rsh;
		side_s3 <= side_s2;
		gq_s3   <= gq_s2;
		side_s4 <= side_s3;
		gq_s4   <= gq_s3;
	end

	always_ff @(posedge clk) begin
		gbl_s3 <= {30'd0, gq_s2[16:0]} * {17'd0, side_s2.bm};
		gbh_s3 <= {30'd0, gq_s2[33:17]} * {17'd0, side_s2.bm};
	end

	always_ff @(posedge clk) begin
		gb_s4 <= gb_full[63:BetaFracBits];
	end

	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		gel_s5  <= $signed({1'b0, gq_s4[16:0]})  * side_s4.energy;
		geh_s5  <= $signed({1'b0, gq_s4[33:17]}) * side_s4.energy;
		gzl_s5  <= $signed({1'b0, gq_s4[16:0]})  * side_s4.pz;
		gzh_s5  <= $signed({1'b0, gq_s4[33:17]}) * side_s4.pz;
		bzl_s5  <= $signed({1'b0, gb_s4[16:0]})  * side_s4.pz;
		bzh_s5  <= $signed({1'b0, gb_s4[33:17]}) * side_s4.pz;
		bel_s5  <= $signed({1'b0, gb_s4[16:0]})  * side_s4.energy;
		beh_s5  <= $signed({1'b0, gb_s4[33:17]}) * side_s4.energy;
	end

	always_ff @(posedge clk) begin
		side_s6 <= side_s5;
		ge_s6   <= (67'(geh_s5) <<< 17) + 67'(gel_s5);
		gz_s6   <= (67'(gzh_s5) <<< 17) + 67'(gzl_s5);
		bz_s6   <= (67'(bzh_s5) <<< 17) + 67'(bzl_s5);
		be_s6   <= (67'(beh_s5) <<< 17) + 67'(bel_s5);
	end

	always_ff @(posedge clk) begin
		side_s7 <= side_s6;
		if (side_s6.bneg) begin
			eo_s7 <= ge_s6 + bz_s6;
			zo_s7 <= gz_s6 + be_s6;
		end else begin
			eo_s7 <= ge_s6 - bz_s6;
			zo_s7 <= gz_s6 - be_s6;
		end
	end

	// arithmetic shift gives the floor
	assign et    = 49'(eo_s7 >>> GammaFracBits);
	assign zt    = 49'(zo_s7 >>> GammaFracBits);
	assign e_ovf = (et[48:31] != {18{et[31]}});
	assign z_ovf = (zt[48:31] != {18{zt[31]}});

	always_ff @(posedge clk) begin
		out_px  <= side_s7.px;
		out_py  <= side_s7.py;
		out_ovf <= e_ovf | z_ovf;
		if (e_ovf) begin
			out_energy <= et[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			out_energy <= et[31:0];
		end
		if (z_ovf) begin
			out_pz <= zt[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			out_pz <= zt[31:0];
		end
	end

endmodule

// ----- src/lorentz_boost_z_core.sv -----
`timescale 1ns / 1ps
// Lorentz boost along z, fixed point, fully pipelined over 80 register stages.
// Throughput: one item per cycle; the 31-step square root and the 34-step
// reciprocal divider are unrolled into stages. busy is always low.
// Reset clears the valid bits only; the receiver cannot stall the pipeline.
module lorentz_boost_z_core import lbz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [30:0] beta,
	input  logic signed [31:0] energy_in,
	input  logic signed [31:0] px_in,
	input  logic signed [31:0] py_in,
	input  logic signed [31:0] pz_in,
	output logic               done,
	output logic signed [31:0] energy_out,
	output logic signed [31:0] px_out,
	output logic signed [31:0] py_out,
	output logic signed [31:0] pz_out,
	output logic               overflow
);

	localparam logic [30:0] BetaMax = (31'd1 << BetaFracBits) - 31'd1;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	lbz_side_t   side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [59:0] sq_s2;
	logic [61:0] d_s3, d_s4, d_s5, d_s6, d_s7;
	logic [30:0] mag;
	logic        sq_valid;
	logic [30:0] sq_root;
	lbz_side_t   sq_side;
	logic        rc_valid;
	logic [33:0] rc_quo;
	lbz_side_t   rc_side;

	function automatic lbz_side_t add_pairs(input lbz_side_t s, input logic [3:0] k);
		lbz_side_t r;
		r   = s;
		r.m = s.m + k;
		return r;
	endfunction

	assign busy = 1'b0;
	assign mag  = beta[30] ? 31'(-beta) : 31'(beta);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.energy <= energy_in;
		side_s1.px     <= px_in;
		side_s1.py     <= py_in;
		side_s1.pz     <= pz_in;
		side_s1.bneg   <= beta[30];
		side_s1.m      <= '0;
		// clamp a magnitude at or beyond one, keep the sign
		side_s1.bm     <= (mag > BetaMax) ? BetaMax[29:0] : mag[29:0];
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		sq_s2   <= {30'd0, side_s1.bm} * {30'd0, side_s1.bm};
		side_s3 <= side_s2;
		d_s3    <= (62'd1 << (2 * BetaFracBits)) - {2'b00, sq_s2};
	end

	// normalise by pairs of bits: 8, 4, 2, then 1 pair
	always_ff @(posedge clk) begin
		if (d_s3[61:46] == '0) begin
			d_s4    <= d_s3 << 16;
			side_s4 <= add_pairs(side_s3, 4'd8);
		end else begin
			d_s4    <= d_s3;
			side_s4 <= side_s3;
		end
		if (d_s4[61:54] == '0) begin
			d_s5    <= d_s4 << 8;
			side_s5 <= add_pairs(side_s4, 4'd4);
		end else begin
			d_s5    <= d_s4;
			side_s5 <= side_s4;
		end
		if (d_s5[61:58] == '0) begin
			d_s6    <= d_s5 << 4;
			side_s6 <= add_pairs(side_s5, 4'd2);
		end else begin
			d_s6    <= d_s5;
			side_s6 <= side_s5;
		end
		if (d_s6[61:60] == '0) begin
			d_s7    <= d_s6 << 2;
			side_s7 <= add_pairs(side_s6, 4'd1);
		end else begin
			d_s7    <= d_s6;
			side_s7 <= side_s6;
		end
	end

	lbz_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.in_rad    (d_s7),
		.in_side   (side_s7),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	lbz_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_root   (sq_root),
		.in_side   (sq_side),
		.out_valid (rc_valid),
		.out_quo   (rc_quo),
		.out_side  (rc_side)
	);

	lbz_boost u_boost (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rc_valid),
		.in_quo     (rc_quo),
		.in_side    (rc_side),
		.out_valid  (done),
		.out_energy (energy_out),
		.out_px     (px_out),
		.out_py     (py_out),
		.out_pz     (pz_out),
		.out_ovf    (overflow)
	);

endmodule

// ----- test/lbz_checker.sv -----
`timescale 1ns / 1ps
module lbz_checker import lbz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [30:0] beta,
	input  logic signed [31:0] energy_in,
	input  logic signed [31:0] px_in,
	input  logic signed [31:0] py_in,
	input  logic signed [31:0] pz_in,
	input  logic               done,
	input  logic signed [31:0] energy_out,
	input  logic signed [31:0] px_out,
	input  logic signed [31:0] py_out,
	input  logic signed [31:0] pz_out,
	input  logic               overflow,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic signed [31:0] energy;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic               ovf;
	} boosted_t;

	boosted_t boosted_q[$];
	int       result_no;

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] x,
			inout logic ovf);
		if (x > 128'sd2147483647) begin
			ovf = 1'b1;
			return 32'sh7fffffff;
		end
		if (x < -128'sd2147483648) begin
			ovf = 1'b1;
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic boosted_t boost_z(input logic signed [30:0] b,
			input logic signed [31:0] e, input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		boosted_t            r;
		logic                bneg;
		logic [63:0]         bm;
		logic [63:0]         d;
		logic [63:0]         s;
		logic [63:0]         gq;
		logic [127:0]        prod;
		logic signed [127:0] gqs;
		logic signed [127:0] gbs;
		logic signed [127:0] es;
		logic signed [127:0] zs;
		logic signed [127:0] acc;
		int                  m;
		bneg = b < 0;
		bm = bneg ? 64'(-64'(b)) : 64'(b);
		// beta at or beyond one: clamp the magnitude, keep the sign
		if (bm > (64'd1 << BetaFracBits) - 1)
			bm = (64'd1 << BetaFracBits) - 1;
		d = (64'd1 << (2 * BetaFracBits)) - bm * bm;
		m = 0;
		while (d < (64'd1 << 60)) begin
			d = d << 2;
			m++;
		end
		s = int_sqrt(d);
		gq = (64'd1 << (BetaFracBits + m + GammaFracBits)) / s;
		prod = 128'(gq) * 128'(bm);
		prod = prod >> BetaFracBits;
		gqs = $signed({64'd0, gq});
		gbs = bneg ? -$signed(prod) : $signed(prod);
		es = e;
		zs = pz;
		r.ovf = 1'b0;
		acc = (gqs * es - gbs * zs) >>> GammaFracBits;
		r.energy = clamp32(acc, r.ovf);
		acc = (gqs * zs - gbs * es) >>> GammaFracBits;
		r.pz = clamp32(acc, r.ovf);
		r.px = px;
		r.py = py;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: result %0d %s got %h want %h", $realtime, result_no, what,
			got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		result_no = 0;
	end

	assign pending = boosted_q.size();

	always @(posedge clk) begin
		boosted_t w;
		if (arst_n) begin
			if (start && !busy)
				boosted_q.push_back(boost_z(beta, energy_in, px_in, py_in, pz_in));
			if (done) begin
				if (boosted_q.size() == 0) begin
					report_mismatch("unexpected", energy_out, 0);
				end else begin
					w = boosted_q.pop_front();
					if (energy_out !== w.energy)
						report_mismatch("energy", energy_out, w.energy);
					if (px_out !== w.px)
						report_mismatch("px", px_out, w.px);
					if (py_out !== w.py)
						report_mismatch("py", py_out, w.py);
					if (pz_out !== w.pz)
						report_mismatch("pz", pz_out, w.pz);
					if (overflow !== w.ovf)
						report_mismatch("overflow", 32'(overflow), 32'(w.ovf));
				end
				result_no++;
			end
		end
	end

endmodule

// ----- test/tb_lorentz_boost_z_core.sv -----
`timescale 1ns / 1ps
module tb_lorentz_boost_z_core import lbz_pkg::*; ();

	localparam int CycleLimit = 200000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [30:0] beta;
	logic signed [31:0] energy_in;
	logic signed [31:0] px_in;
	logic signed [31:0] py_in;
	logic signed [31:0] pz_in;
	logic               done;
	logic signed [31:0] energy_out;
	logic signed [31:0] px_out;
	logic signed [31:0] py_out;
	logic signed [31:0] pz_out;
	logic               overflow;
	int                 errors;
	int                 pending;
	int                 cycles;
	int                 idle_pct;

	lorentz_boost_z_core uut (.*);

	lbz_checker chk (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_item(input logic signed [30:0] b, input logic signed [31:0] e,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z);
		// hold start low for a random gap first
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		beta      <= b;
		energy_in <= e;
		px_in     <= x;
		py_in     <= y;
		pz_in     <= z;
		start     <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic signed [30:0] rand_beta();
		case ($urandom_range(3))
			0: return 31'($urandom);
			1: return 31'sd1073741823 - 31'($urandom_range(4095));
			2: return -31'sd1073741823 + 31'($urandom_range(4095));
			default: return 31'($signed(16'($urandom)));
		endcase
	endfunction

	function automatic logic signed [31:0] rand_mom();
		if ($urandom_range(2) == 0)
			return $urandom;
		return 32'($signed(20'($urandom)));
	endfunction

	initial begin
		cycles    = 0;
		idle_pct  = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		beta      = '0;
		energy_in = '0;
		px_in     = '0;
		py_in     = '0;
		pz_in     = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero beta, beta extremes and the clamped pattern, field extremes
		send_item(31'sd0, 32'sh00010000, 32'sh7fffffff, 32'sh80000000, 32'sh00008000);
		send_item(31'sd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		send_item(31'sh40000000, 32'sh00010000, 32'sd1, -32'sd1, 32'sh00010000);
		send_item(31'sh40000000, 32'sh00020000, 32'sd0, 32'sd0, -32'sh00010000);
		send_item(31'sh3fffffff, 32'sh00010000, 32'sd5, 32'sd7, 32'sd0);
		send_item(-31'sh3fffffff, 32'sh00010000, 32'sd5, 32'sd7, 32'sd0);
		send_item(31'sh3fffffff, 32'sh00010000, 32'sd0, 32'sd0, 32'sh00010000);
		send_item(31'sh3fffffff, 32'sh7fffffff, 32'sd0, 32'sd0, 32'sh80000000);
		send_item(-31'sh3fffffff, 32'sh80000000, 32'sd0, 32'sd0, 32'sh80000000);
		send_item(31'sh20000000, 32'sh7fffffff, 32'sd1, 32'sd2, 32'sh7fffffff);
		send_item(-31'sh20000000, 32'sh80000000, 32'sd3, 32'sd4, 32'sh7fffffff);
		send_item(31'sd1, 32'sh7fffffff, 32'sd0, 32'sd0, 32'sh7fffffff);
		send_item(-31'sd1, 32'sh80000000, 32'sd0, 32'sd0, 32'sh80000000);
		send_item(31'sh20000000, 32'sh00050000, 32'sh00010000, 32'sh00020000,
			32'sh00030000);
		send_item(31'sh3fff0000, 32'sh00100000, 32'sd0, 32'sd0, -32'sh00100000);
		send_item(31'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_item(31'sh7fffffff, -32'sd1, -32'sd1, -32'sd1, -32'sd1);

		for (int i = 0; i < 750; i++) begin
			idle_pct = (i < 250) ? 26 : (i < 500) ? 73 : 0;
			send_item(rand_beta(), rand_mom(), $urandom, $urandom, rand_mom());
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/lbz_pkg.sv
src/lbz_isqrt.sv
src/lbz_recip.sv
src/lbz_boost.sv
src/lorentz_boost_z_core.sv
test/lbz_checker.sv
test/tb_lorentz_boost_z_core.sv
